// File: src/wma_pkg.sv
// ----------------------------------------------------------------------------
// wma_pkg: shared types and constants of the weighted moving average pair
// Sample width, default ring depth, width helpers and the pipeline control
// group that the top level hands to the datapath modules.
// ----------------------------------------------------------------------------
package wma_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int DEPTH_DEFAULT = 8;

    // Control that the top level hands to each channel datapath.
    typedef struct packed {
        logic upd;   // stage A item moves into the running sums
        logic ld_c;  // magnitude stage loads
        logic ld_d;  // multiply stage loads
        logic ld_o;  // result register loads
    } t_pipe_ctl;

    // Address width of a ring; a single-entry ring still gets one bit.
    function automatic int addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Width of the weighted sum, which reaches 2^15 * DEPTH*(DEPTH+1)/2.
    function automatic int wsum_width(input int depth);
        return SAMPLE_W + $clog2(depth * (depth + 1) / 2) + 1;
    endfunction

endpackage

// File: src/wma_in_if.sv
// ----------------------------------------------------------------------------
// wma_in_if: input channel of the weighted moving average pair
// Valid/ready channel that carries one left and one right sample.
// ----------------------------------------------------------------------------
interface wma_in_if;

    logic                                valid;
    logic                                ready;
    logic signed [wma_pkg::SAMPLE_W-1:0] left_sample;
    logic signed [wma_pkg::SAMPLE_W-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);

endinterface

// File: src/wma_out_if.sv
// ----------------------------------------------------------------------------
// wma_out_if: output channel of the weighted moving average pair
// Valid/ready channel that carries one left and one right smoothed value.
// ----------------------------------------------------------------------------
interface wma_out_if;

    logic                                valid;
    logic                                ready;
    logic signed [wma_pkg::SAMPLE_W-1:0] left_smoothed;
    logic signed [wma_pkg::SAMPLE_W-1:0] right_smoothed;

    modport source (output valid, output left_smoothed, output right_smoothed, input ready);
    modport sink   (input valid, input left_smoothed, input right_smoothed, output ready);

endinterface

// File: src/wma_ram.sv
// ----------------------------------------------------------------------------
// wma_ram: generic simple dual-port RAM
// One write port and one read port with registered read data. A read of the
// address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module wma_ram #(
    parameter int WIDTH = wma_pkg::SAMPLE_W,
    parameter int DEPTH = wma_pkg::DEPTH_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [wma_pkg::addr_width(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [wma_pkg::addr_width(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    import wma_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/wma_sum.sv
// ----------------------------------------------------------------------------
// wma_sum: running sums of one channel
// Keeps the plain sum and the linearly weighted sum of the ring. A new sample
// enters with weight DEPTH while every older sample loses one unit of weight,
// which is the same as subtracting the plain sum.
// ----------------------------------------------------------------------------
module wma_sum #(
    parameter int DEPTH = wma_pkg::DEPTH_DEFAULT
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  wma_pkg::t_pipe_ctl                           i_ctl,
    input  logic signed [wma_pkg::SAMPLE_W-1:0]          i_sample,
    input  logic        [wma_pkg::SAMPLE_W-1:0]          i_old,
    input  logic                                         i_old_valid,
    output logic signed [wma_pkg::wsum_width(DEPTH)-1:0] o_wsum
);
    import wma_pkg::*;

    localparam int SUM_W  = SAMPLE_W + $clog2(DEPTH) + 1;
    localparam int WSUM_W = wsum_width(DEPTH);
    localparam logic signed [WSUM_W-1:0] DEPTH_S = WSUM_W'(DEPTH);

    logic signed [SAMPLE_W-1:0] old_s;
    logic signed [SUM_W-1:0]    r_s;
    logic signed [SUM_W-1:0]    n_s;
    logic signed [WSUM_W-1:0]   r_w;
    logic signed [WSUM_W-1:0]   n_w;

    // An entry not yet written since reset counts as zero.
    assign old_s = i_old_valid ? $signed(i_old) : '0;

    assign n_s = r_s + SUM_W'(i_sample) - SUM_W'(old_s);
    assign n_w = r_w + WSUM_W'(i_sample) * DEPTH_S - WSUM_W'(r_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
            r_w <= '0;
        end else if (i_ctl.upd) begin
            r_s <= n_s;
            r_w <= n_w;
        end
    end

    assign o_wsum = r_w;

endmodule

// File: src/wma_div.sv
// ----------------------------------------------------------------------------
// wma_div: division of a weighted sum by DEPTH*(DEPTH+1)/2
// Three stages: sign and magnitude, multiplication by a rounded-up reciprocal,
// then shift and restore the sign. The reciprocal is exact over the whole
// magnitude range, so the quotient truncates toward zero.
// ----------------------------------------------------------------------------
module wma_div #(
    parameter int DEPTH = wma_pkg::DEPTH_DEFAULT
) (
    input  logic                                         i_clk,
    input  wma_pkg::t_pipe_ctl                           i_ctl,
    input  logic signed [wma_pkg::wsum_width(DEPTH)-1:0] i_wsum,
    output logic signed [wma_pkg::SAMPLE_W-1:0]          o_result
);
    import wma_pkg::*;

    localparam int     WSUM_W  = wsum_width(DEPTH);
    localparam longint DIVISOR = longint'(DEPTH) * (DEPTH + 1) / 2;
    localparam longint MAG_MAX = longint'(2 ** (SAMPLE_W - 1)) * DIVISOR;
    localparam int     MAG_W   = $clog2(MAG_MAX + 1);
    localparam int     LOG_D   = $clog2(DIVISOR);
    localparam int     SHIFT   = MAG_W + LOG_D;
    localparam int     RECIP_W = MAG_W + 2;
    localparam int     PROD_W  = MAG_W + RECIP_W;
    localparam int     QUOT_W  = SAMPLE_W + 1;
    localparam longint RECIP   = ((longint'(1) << SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

    logic                       n_neg;
    logic [WSUM_W-1:0]          abs_full;
    logic [MAG_W-1:0]           r_mag;
    logic                       r_neg_c;
    logic [PROD_W-1:0]          n_prod;
    logic [PROD_W-1:0]          r_prod;
    logic                       r_neg_d;
    logic [QUOT_W-1:0]          quot;
    logic [QUOT_W-1:0]          quot_sgn;
    logic signed [SAMPLE_W-1:0] r_result;

    assign n_neg    = i_wsum[WSUM_W-1];
    assign abs_full = n_neg ? WSUM_W'(-i_wsum) : WSUM_W'(i_wsum);
    assign n_prod   = r_mag * RECIP_V;
    assign quot     = r_prod[SHIFT +: QUOT_W];
    assign quot_sgn = r_neg_d ? QUOT_W'(-quot) : quot;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_c) begin
            r_mag   <= MAG_W'(abs_full);
            r_neg_c <= n_neg;
        end
        if (i_ctl.ld_d) begin
            r_prod  <= n_prod;
            r_neg_d <= r_neg_c;
        end
        if (i_ctl.ld_o) begin
            r_result <= $signed(quot_sgn[SAMPLE_W-1:0]);
        end
    end

    assign o_result = r_result;

endmodule

// File: src/weighted_moving_average_pair.sv
// ----------------------------------------------------------------------------
// weighted_moving_average_pair: two-channel linearly weighted moving average
// Smooths a left and a right command stream. Each output is the weighted sum
// of the last DEPTH samples of its channel, newest weight DEPTH, oldest
// weight 1, divided by DEPTH*(DEPTH+1)/2 and truncated toward zero.
//
//   Channel  Direction  Handshake      Payload
//   i_in     in         valid / ready  left_sample, right_sample (s16 Q1.15)
//   o_out    out        valid / ready  left_smoothed, right_smoothed (s16)
//
// One transaction is accepted per clock while the output is not held off;
// its result passes through stages A (sample and ring read), B (running
// sums), C (magnitude), D (reciprocal multiply) and the output register.
// Reset is synchronous and active low; it zeroes the running sums, the write
// position and the lap flag, so both rings read as all zero at once.
// Each stage holds only while its successor is full and stalled, so bubbles
// close up and the input stays ready until all five stages are occupied.
// ----------------------------------------------------------------------------
module weighted_moving_average_pair #(
    parameter int DEPTH = wma_pkg::DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wma_in_if.sink    i_in,
    wma_out_if.source o_out
);
    import wma_pkg::*;

    localparam int PTR_W  = addr_width(DEPTH);
    localparam int WSUM_W = wsum_width(DEPTH);

    // Stage enables: a stage loads when it is empty or its successor moves.
    logic en_a;
    logic en_b;
    logic en_c;
    logic en_d;
    logic en_o;
    logic accept;

    // Stage valid flags. Stage B data lives in the running sum registers.
    logic r_va;
    logic r_vb;
    logic r_vc;
    logic r_vd;
    logic r_vo;

    // Ring write position, shared by both channels, and the lap flag. Once a
    // full lap is done, the entry at the write position holds a real sample;
    // before that it has not been written since reset and is taken as zero.
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] n_wp;
    logic             r_wrapped;
    logic             at_last;

    // Stage A payload. The overwritten ring entries arrive from the RAMs.
    logic signed [SAMPLE_W-1:0] r_left_a;
    logic signed [SAMPLE_W-1:0] r_right_a;
    logic                       r_oldv_a;
    logic [SAMPLE_W-1:0]        left_old;
    logic [SAMPLE_W-1:0]        right_old;

    logic signed [WSUM_W-1:0]   left_wsum;
    logic signed [WSUM_W-1:0]   right_wsum;
    logic signed [SAMPLE_W-1:0] left_res;
    logic signed [SAMPLE_W-1:0] right_res;

    t_pipe_ctl ctl;

    assign en_o   = !r_vo || o_out.ready;
    assign en_d   = !r_vd || en_o;
    assign en_c   = !r_vc || en_d;
    assign en_b   = !r_vb || en_c;
    assign en_a   = !r_va || en_b;
    assign accept = i_in.valid && en_a;

    assign i_in.ready = en_a;

    assign ctl.upd  = r_va && en_b;
    assign ctl.ld_c = en_c;
    assign ctl.ld_d = en_d;
    assign ctl.ld_o = en_o;

    assign at_last = (r_wp == PTR_W'(DEPTH - 1));
    assign n_wp    = at_last ? '0 : r_wp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va      <= 1'b0;
            r_vb      <= 1'b0;
            r_vc      <= 1'b0;
            r_vd      <= 1'b0;
            r_vo      <= 1'b0;
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= accept;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
            if (en_c) begin
                r_vc <= r_vb;
            end
            if (en_d) begin
                r_vd <= r_vc;
            end
            if (en_o) begin
                r_vo <= r_vd;
            end
            if (accept) begin
                r_wp <= n_wp;
                if (at_last) begin
                    r_wrapped <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left_a  <= i_in.left_sample;
            r_right_a <= i_in.right_sample;
            r_oldv_a  <= r_wrapped;
        end
    end

    // Each ring writes the new sample and reads the entry it replaces in the
    // same cycle; the RAM returns the old contents.
    wma_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_left_ring (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wp),
        .i_wdata (i_in.left_sample),
        .i_re    (accept),
        .i_raddr (r_wp),
        .o_rdata (left_old)
    );

    wma_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_right_ring (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wp),
        .i_wdata (i_in.right_sample),
        .i_re    (accept),
        .i_raddr (r_wp),
        .o_rdata (right_old)
    );

    wma_sum #(.DEPTH(DEPTH)) u_left_sum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_sample    (r_left_a),
        .i_old       (left_old),
        .i_old_valid (r_oldv_a),
        .o_wsum      (left_wsum)
    );

    wma_sum #(.DEPTH(DEPTH)) u_right_sum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_sample    (r_right_a),
        .i_old       (right_old),
        .i_old_valid (r_oldv_a),
        .o_wsum      (right_wsum)
    );

    wma_div #(.DEPTH(DEPTH)) u_left_div (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_wsum   (left_wsum),
        .o_result (left_res)
    );

    wma_div #(.DEPTH(DEPTH)) u_right_div (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_wsum   (right_wsum),
        .o_result (right_res)
    );

    assign o_out.valid          = r_vo;
    assign o_out.left_smoothed  = left_res;
    assign o_out.right_smoothed = right_res;

`ifndef SYNTH
    // The write position never leaves the ring.
    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= PTR_W'(DEPTH - 1))
        else $error("write position beyond ring depth");

    // Once a full lap is done, the lap flag stays set until reset.
    a_wrapped_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wrapped |=> r_wrapped)
        else $error("lap flag dropped without reset");

    // The input is held off only when every stage is occupied.
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_va && r_vb && r_vc && r_vd && r_vo))
        else $error("input stalled with a stage empty");

    // An accepted transaction always reaches stage A.
    a_accept_to_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_va)
        else $error("accepted transaction missing from stage A");
`endif

endmodule

// File: bench/wma_smoothing_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_smoothing_checker: result checker for the weighted moving average pair
// Watches both channels and keeps its own copy of the two sample rings. It
// predicts the smoothed pair for every accepted input transaction and
// compares each accepted output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module wma_smoothing_checker #(
    parameter int DEPTH = wma_pkg::DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    wma_in_if    i_in,
    wma_out_if   i_out,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked
);

    typedef logic signed [wma_pkg::SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } smoothed_pair_t;

    // Sum of the weights 1..DEPTH.
    localparam longint WEIGHT_TOTAL = DEPTH * (DEPTH + 1) / 2;

    sample_t        left_ring [DEPTH];
    sample_t        right_ring [DEPTH];
    int             write_slot;
    smoothed_pair_t smoothed_due [$];
    int             err_count = 0;
    int             check_count = 0;

    // Weighted mean of one ring. The entry at write_slot is the oldest and
    // gets weight 1; the newest gets weight DEPTH. Division truncates toward
    // zero, as signed integer division does.
    function automatic sample_t weighted_mean(input bit use_right);
        longint acc;
        longint quot;
        int     idx;
        acc = 0;
        for (int k = 0; k < DEPTH; k++) begin
            idx = (write_slot + k) % DEPTH;
            acc += longint'(use_right ? right_ring[idx] : left_ring[idx]) * longint'(k + 1);
        end
        quot = acc / WEIGHT_TOTAL;
        return quot[wma_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic note_error(input string what, input sample_t want, input sample_t got);
        if (err_count < 10) begin
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        end
        err_count++;
    endtask

    always @(posedge i_clk) begin
        smoothed_pair_t want;
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                left_ring[k]  = '0;
                right_ring[k] = '0;
            end
            write_slot = 0;
            smoothed_due.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                left_ring[write_slot]  = i_in.left_sample;
                right_ring[write_slot] = i_in.right_sample;
                write_slot = (write_slot + 1) % DEPTH;
                want.left  = weighted_mean(1'b0);
                want.right = weighted_mean(1'b1);
                smoothed_due.push_back(want);
            end
            if (i_out.valid && i_out.ready) begin
                check_count++;
                if (smoothed_due.size() == 0) begin
                    if (err_count < 10) begin
                        $display("[%0t] unexpected output transaction: left %0d, right %0d",
                                 $realtime, i_out.left_smoothed, i_out.right_smoothed);
                    end
                    err_count++;
                end else begin
                    want = smoothed_due.pop_front();
                    if (i_out.left_smoothed !== want.left) begin
                        note_error("left_smoothed", want.left, i_out.left_smoothed);
                    end
                    if (i_out.right_smoothed !== want.right) begin
                        note_error("right_smoothed", want.right, i_out.right_smoothed);
                    end
                end
            end
        end
        o_errors  <= err_count;
        o_pending <= smoothed_due.size();
        o_checked <= check_count;
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the weighted moving average pair
// Drives sample pairs into the block, a short directed set first and then
// segments of held levels, ramps, small values and noise, while both sides
// idle at random. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

    import wma_pkg::*;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam sample_t S_MAX = 16'sh7FFF;
    localparam sample_t S_MIN = 16'sh8000;

    // Random sample pairs in total, split around the pressure phase.
    localparam int RANDOM_ITEMS = 800;
    // The last random items run with no idling on either side.
    localparam int CALM_TAIL    = 150;
    // Items offered while the output is held off; well past the pipeline depth.
    localparam int HOLD_BURST   = 24;
    // Length of the long output stall in cycles.
    localparam int LONG_HOLD    = 60;
    // Cycles to wait after the last result.
    localparam int TAIL_CYCLES  = 20;
    // Watchdog limit, several times the slowest correct run with the long stall.
    localparam int CYCLE_LIMIT  = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wma_in_if  in_ch ();
    wma_out_if out_ch ();

    int errors;
    int pending;
    int checked;

    // Stimulus controls shared between the sender and the receiver process.
    bit src_idle_on  = 1'b0;
    bit sink_idle_on = 1'b0;
    bit hold_req     = 1'b0;

    int          items_sent   = 0;
    int          random_sent  = 0;
    int          long_holds   = 0;
    int          stall_cycles = 0;
    int unsigned cycle_cnt    = 0;

    weighted_moving_average_pair u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    wma_smoothing_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Cycle count for the watchdog, plus a count of cycles in which the block
    // pushed back on an offered transaction.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (in_ch.valid && !in_ch.ready) begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("Timed out after %0d cycles with %0d results outstanding", cycle_cnt, pending);
        $display("FAIL weighted_moving_average_pair");
        $finish;
    end

    // Receiver. Each pass makes exactly one assignment to ready and then waits
    // on the clock before the next pass. A hold request from the sender turns
    // into one long stall, counted here; otherwise ready drops in short random
    // bursts while idling is enabled.
    initial begin : receiver
        int stall;
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                long_holds++;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 14);
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one sample pair and wait for the transaction. Valid stays high
    // on return so that back-to-back pairs need no second assignment in the
    // same time step; a random gap lowers it once and then waits.
    task automatic send_pair(input sample_t left, input sample_t right);
        int gap;
        in_ch.valid        <= 1'b1;
        in_ch.left_sample  <= left;
        in_ch.right_sample <= right;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Lower valid and wait until every predicted result has come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // A starting level for a segment: often a full-scale or near-zero value,
    // otherwise anything in range.
    function automatic sample_t pick_level();
        case ($urandom_range(0, 6))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return sample_t'(int'($urandom_range(0, 64)) - 32);
            default: return sample_t'($urandom());
        endcase
    endfunction

    // Next value of a segment: 0 holds the level (a step input), 1 ramps with
    // saturation at full scale, 2 is full-range noise, 3 is small values near
    // zero where truncation toward zero matters most.
    function automatic sample_t next_value(input int kind, input sample_t cur, input int step);
        int t;
        case (kind)
            0: return cur;
            1: begin
                t = int'(cur) + step;
                if (t > 32767) t = 32767;
                if (t < -32768) t = -32768;
                return sample_t'(t);
            end
            2:       return sample_t'($urandom());
            default: return sample_t'(int'($urandom_range(0, 40)) - 20);
        endcase
    endfunction

    // Random segments of 1 to 16 pairs; the two channels pick their shapes
    // independently. Idling is re-chosen at each segment so that some
    // stretches run with no gaps, and it is off near the end of the run.
    task automatic random_run(input int count);
        int      done;
        int      seg_len;
        int      l_kind;
        int      r_kind;
        int      l_step;
        int      r_step;
        bit      calm;
        sample_t l_val;
        sample_t r_val;
        done = 0;
        while (done < count) begin
            seg_len = $urandom_range(1, 16);
            l_kind  = $urandom_range(0, 3);
            r_kind  = $urandom_range(0, 3);
            l_step  = int'($urandom_range(0, 8192)) - 4096;
            r_step  = int'($urandom_range(0, 8192)) - 4096;
            l_val   = pick_level();
            r_val   = pick_level();
            calm    = (random_sent >= RANDOM_ITEMS - CALM_TAIL);
            src_idle_on  = !calm && ($urandom_range(0, 2) != 0);
            sink_idle_on = !calm && ($urandom_range(0, 2) != 0);
            for (int k = 0; k < seg_len && done < count; k++) begin
                send_pair(l_val, r_val);
                l_val = next_value(l_kind, l_val, l_step);
                r_val = next_value(r_kind, r_val, r_step);
                done++;
                random_sent++;
            end
        end
    endtask

    initial begin : stimulus
        int directed;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.left_sample  <= '0;
        in_ch.right_sample <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with light idling on both sides. The first pairs
        // arrive while the rings still count as zero, so the output ramps up
        // from zero; small negative and positive values check that the quotient
        // truncates toward zero.
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_pair('0, '0);
        send_pair(-16'sd1, 16'sd1);
        send_pair(-16'sd5, 16'sd5);
        // A full ring of extremes must give exactly full scale on each side,
        // and this run also takes the write position around the wrap.
        repeat (8) send_pair(S_MAX, S_MIN);
        // Swap the extremes so each ring moves through its whole range.
        repeat (3) send_pair(S_MIN, S_MAX);
        repeat (2) begin
            send_pair(S_MAX, S_MIN);
            send_pair(S_MIN, S_MAX);
        end
        repeat (2) send_pair(-16'sd37, 16'sd37);
        send_pair(16'sd1, -16'sd1);
        directed = items_sent;

        random_run(RANDOM_ITEMS / 2);

        // Back pressure: hold the output off for a long stretch while pairs
        // keep coming with no gaps, so the pipeline fills and the input stalls.
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_req     = 1'b1;
        for (int k = 0; k < HOLD_BURST; k++) begin
            send_pair(sample_t'($urandom()), sample_t'($urandom()));
        end

        // Let the block empty completely before the second half.
        drain_results();

        random_run(RANDOM_ITEMS - RANDOM_ITEMS / 2);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d sample pairs (%0d directed, %0d in a stall burst), checked %0d results",
                 items_sent, directed, HOLD_BURST, checked);
        $display("Saw %0d long output stall(s) and %0d cycles of input back pressure",
                 long_holds, stall_cycles);
        if (errors == 0) begin
            $display("PASS weighted_moving_average_pair");
        end else begin
            $display("FAIL weighted_moving_average_pair");
        end
        $finish;
    end

endmodule
